// ----- rtl/nsfp_pkg.sv -----
`timescale 1ns / 1ps

package nsfp_pkg;

    localparam int SAT_SLOTS_DEF      = 32;
    localparam int GROUPS_PER_GSV_DEF = 4;
    localparam int OUTQ_DEPTH         = 4;
    localparam int OUTQ_CNT_W         = 3;

    localparam logic [23:0] VAL_MAX   = 24'hFFFFFF;
    localparam logic [9:0]  INT_CAP   = 10'd1023;

    localparam logic OP_READ     = 1'b1;
    localparam logic RK_STATUS   = 1'b0;
    localparam logic RK_SLOT     = 1'b1;
    localparam logic ERR_OK      = 1'b0;
    localparam logic ERR_MISSING = 1'b1;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_N      = 8'h4E;

    localparam logic [39:0] TAG_GGA = 40'h4750474741;
    localparam logic [39:0] TAG_GLL = 40'h4750474C4C;
    localparam logic [39:0] TAG_RMC = 40'h4750524D43;
    localparam logic [39:0] TAG_VTG = 40'h4750565447;
    localparam logic [39:0] TAG_GSV = 40'h4750475356;

    typedef enum logic [2:0] {
        K_GGA   = 3'd0,
        K_GLL   = 3'd1,
        K_RMC   = 3'd2,
        K_VTG   = 3'd3,
        K_GSV   = 3'd4,
        K_OTHER = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        BC_DOLLAR,
        BC_COMMA,
        BC_LF,
        BC_DIGIT,
        BC_DOT,
        BC_SIGN,
        BC_OTHER
    } t_byte_cls;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic [4:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  sentence_type;
        logic        error_code;
        logic        fix_alive;
        logic [23:0] speed_m_per_h;
        logic [9:0]  heading;
        logic        sat_valid;
        logic [6:0]  sat_elevation;
        logic [8:0]  sat_azimuth;
        logic [6:0]  sat_snr;
    } t_out_item;

    typedef struct packed {
        logic       is_read;
        t_byte_cls  cls;
        logic [7:0] data_byte;
        logic [4:0] slot_index;
    } t_cmd;

    typedef struct packed {
        logic                  valid;
        logic [OUTQ_CNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic [3:0] q;
        logic [9:0] r;
    } t_qr;

    typedef struct packed {
        logic [10:0] qf;
        logic [9:0]  rf;
    } t_wt;

    function automatic t_kind classify(input logic [39:0] letters, input logic [2:0] len);
        t_kind k;
        k = K_OTHER;
        if (len == 3'd5) begin
            case (letters)
                TAG_GGA: k = K_GGA;
                TAG_GLL: k = K_GLL;
                TAG_RMC: k = K_RMC;
                TAG_VTG: k = K_VTG;
                TAG_GSV: k = K_GSV;
                default: k = K_OTHER;
            endcase
        end
        return k;
    endfunction

    function automatic logic [3:0] needed_fields(input t_kind k);
        logic [3:0] n;
        unique case (k)
            K_GGA:   n = 4'd7;
            K_GLL:   n = 4'd7;
            K_RMC:   n = 4'd9;
            K_VTG:   n = 4'd10;
            K_GSV:   n = 4'd3;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Split a value below 10000 into thousands and remainder.
    function automatic t_qr norm1000(input logic [13:0] v);
        t_qr res;
        res.q = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 14'(k * 1000)) res.q = res.q + 4'd1;
        end
        res.r = 10'(v - 14'(res.q) * 14'd1000);
        return res;
    endfunction

    // Weight of one digit times 1852, as whole part and thousandths.
    function automatic t_wt digit_weight(input logic dot, input logic [1:0] fd);
        t_wt w;
        if (!dot) begin
            w.qf = 11'd1852; w.rf = 10'd0;
        end else begin
            case (fd)
                2'd0:    begin w.qf = 11'd185; w.rf = 10'd200; end
                2'd1:    begin w.qf = 11'd18;  w.rf = 10'd520; end
                default: begin w.qf = 11'd1;   w.rf = 10'd852; end
            endcase
        end
        return w;
    endfunction

    function automatic logic [9:0] clamp_int(input logic neg, input logic [9:0] v,
                                             input logic [9:0] maxv);
        logic [9:0] c;
        if (neg) c = 10'd0;
        else if (v > maxv) c = maxv;
        else c = v;
        return c;
    endfunction

endpackage

// ----- rtl/nsfp_front.sv -----
`timescale 1ns / 1ps

module nsfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  nsfp_pkg::t_in_item i_item,
    input  logic              i_pop,
    output logic              o_valid,
    output nsfp_pkg::t_cmd    o_cmd
);

    nsfp_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;
    nsfp_pkg::t_cmd w_cmd;
    logic           w_wr, w_rd;

    // Classify the byte once here so the back end only branches.
    always_comb begin
        w_cmd.is_read    = (i_item.operation == nsfp_pkg::OP_READ);
        w_cmd.data_byte  = i_item.data_byte;
        w_cmd.slot_index = i_item.slot_index;
        unique case (i_item.data_byte) inside
            nsfp_pkg::CH_DOLLAR:                   w_cmd.cls = nsfp_pkg::BC_DOLLAR;
            nsfp_pkg::CH_COMMA:                    w_cmd.cls = nsfp_pkg::BC_COMMA;
            nsfp_pkg::CH_LF:                       w_cmd.cls = nsfp_pkg::BC_LF;
            nsfp_pkg::CH_DOT:                      w_cmd.cls = nsfp_pkg::BC_DOT;
            nsfp_pkg::CH_PLUS, nsfp_pkg::CH_MINUS: w_cmd.cls = nsfp_pkg::BC_SIGN;
            [nsfp_pkg::CH_ZERO:nsfp_pkg::CH_NINE]: w_cmd.cls = nsfp_pkg::BC_DIGIT;
            default:                               w_cmd.cls = nsfp_pkg::BC_OTHER;
        endcase
    end

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = push && !full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= w_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_count <= r_count + 2'(w_wr) - 2'(w_rd);
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("command queue popped while empty");

endmodule

// ----- rtl/nsfp_outq.sv -----
`timescale 1ns / 1ps

module nsfp_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  nsfp_pkg::t_out_item  i_item,
    output logic [nsfp_pkg::OUTQ_CNT_W-1:0] o_count,
    input  logic                 pop,
    output logic                 empty,
    output nsfp_pkg::t_out_item  o_result
);

    localparam int PW = $clog2(nsfp_pkg::OUTQ_DEPTH);

    nsfp_pkg::t_out_item r_mem [nsfp_pkg::OUTQ_DEPTH];
    logic [PW-1:0]       r_wp, r_rp;
    logic [nsfp_pkg::OUTQ_CNT_W-1:0] r_count;
    logic                w_rd;

    assign empty    = (r_count == '0);
    assign o_result = r_mem[r_rp];
    assign o_count  = r_count;
    assign w_rd     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (w_rd)   r_rp <= r_rp + PW'(1);
            r_count <= r_count + nsfp_pkg::OUTQ_CNT_W'(i_push)
                               - nsfp_pkg::OUTQ_CNT_W'(w_rd);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (32'(r_count) < nsfp_pkg::OUTQ_DEPTH))
        else $error("result queue overflow");

endmodule

// ----- rtl/nsfp_back.sv -----
`timescale 1ns / 1ps

module nsfp_back #(
    parameter int SAT_SLOTS      = nsfp_pkg::SAT_SLOTS_DEF,
    parameter int GROUPS_PER_GSV = nsfp_pkg::GROUPS_PER_GSV_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  nsfp_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  nsfp_pkg::t_q_status i_outq,
    output logic                o_res_valid,
    output nsfp_pkg::t_out_item o_res
);

    localparam int FIELD_CAP = (4 * GROUPS_PER_GSV + 4) > 10 ? (4 * GROUPS_PER_GSV + 4) : 10;
    localparam int FN_W      = $clog2(FIELD_CAP + 1);
    localparam int SLOT_W    = SAT_SLOTS > 1 ? $clog2(SAT_SLOTS) : 1;
    localparam int GSV_END   = 4 + 4 * GROUPS_PER_GSV;

    typedef enum logic {PH_IDLE, PH_BUSY} t_phase;

    t_phase              r_phase, n_phase;
    logic [FN_W-1:0]     r_fn, n_fn;
    logic [39:0]         r_letters, n_letters;
    logic [2:0]          r_len, n_len;
    nsfp_pkg::t_kind     r_kind, n_kind;
    logic [7:0]          r_first, n_first;
    logic                r_ne, n_ne, r_dot, n_dot, r_stop, n_stop, r_neg, n_neg;
    logic [1:0]          r_fd, n_fd;
    logic [9:0]          r_int, n_int;
    logic [23:0]         r_q, n_q;
    logic [9:0]          r_r, n_r;
    logic                r_vtg_ok, n_vtg_ok;
    logic [23:0]         r_vtg_spd, n_vtg_spd;
    logic                r_grp_all, n_grp_all, r_grp_idxv, n_grp_idxv;
    logic [SLOT_W-1:0]   r_grp_idx, n_grp_idx;
    logic [6:0]          r_grp_el, n_grp_el;
    logic [8:0]          r_grp_az, n_grp_az;
    logic                r_alive, n_alive;
    logic [23:0]         r_speed, n_speed;
    logic [9:0]          r_heading, n_heading;
    logic [SAT_SLOTS-1:0] r_sat_valid, n_sat_valid;

    logic                r_s2_valid, n_s2_valid;
    nsfp_pkg::t_out_item r_s2_item, n_s2_item;
    logic                r_s2_read, n_s2_read;
    logic                r_s2_ok, n_s2_ok;

    logic [22:0]         r_sat_mem [SAT_SLOTS];
    logic [22:0]         r_rd_data;

    logic                w_go, w_we;
    logic [SLOT_W-1:0]   w_waddr, w_raddr;
    logic [22:0]         w_wdata;
    logic                w_rd_in;
    logic [3:0]          w_d;
    nsfp_pkg::t_kind     w_cur_kind;
    logic [9:0]          w_c127, w_c511, w_c999;
    logic [23:0]         w_spd;
    logic [13:0]         w_int_x, w_rsum;
    logic [27:0]         w_qsum;
    nsfp_pkg::t_wt       w_wt;
    nsfp_pkg::t_qr       w_nq;
    logic [1:0]          w_pos;
    logic                w_in_gsv;

    // Stage 2 needs a free slot in the result queue as well.
    assign w_go      = i_cmd_valid &&
                       (32'(i_outq.count) + 32'(r_s2_valid) < nsfp_pkg::OUTQ_DEPTH);
    assign o_cmd_pop = w_go;

    assign w_d        = 4'(i_cmd.data_byte - nsfp_pkg::CH_ZERO);
    assign w_cur_kind = (r_fn == '0) ? nsfp_pkg::classify(r_letters, r_len) : r_kind;
    assign w_c127     = nsfp_pkg::clamp_int(r_neg, r_int, 10'd127);
    assign w_c511     = nsfp_pkg::clamp_int(r_neg, r_int, 10'd511);
    assign w_c999     = nsfp_pkg::clamp_int(r_neg, r_int, 10'd999);
    assign w_spd      = r_neg ? 24'd0 : r_q;
    assign w_pos      = r_fn[1:0];
    assign w_in_gsv   = (32'(r_fn) >= 4) && (32'(r_fn) < GSV_END);
    assign w_rd_in    = 32'(i_cmd.slot_index) < SAT_SLOTS;
    assign w_raddr    = SLOT_W'(32'(i_cmd.slot_index));

    // Knots held as whole part and thousandths of value*1852, so no divider.
    always_comb begin
        w_int_x = 14'(r_int) * 14'd10 + 14'(w_d);
        w_wt    = nsfp_pkg::digit_weight(r_dot, r_fd);
        if (!r_dot) begin
            w_rsum = 14'(r_r) * 14'd10;
            w_nq   = nsfp_pkg::norm1000(w_rsum);
            w_qsum = 28'(r_q) * 28'd10 + 28'(w_nq.q) + 28'(w_d) * 28'(w_wt.qf);
        end else begin
            w_rsum = 14'(r_r) + 14'(w_d) * 14'(w_wt.rf);
            w_nq   = nsfp_pkg::norm1000(w_rsum);
            w_qsum = 28'(r_q) + 28'(w_d) * 28'(w_wt.qf) + 28'(w_nq.q);
        end
    end

    always_comb begin
        n_phase = r_phase;  n_fn = r_fn;  n_letters = r_letters;  n_len = r_len;
        n_kind = r_kind;  n_first = r_first;  n_ne = r_ne;  n_dot = r_dot;
        n_stop = r_stop;  n_neg = r_neg;  n_fd = r_fd;  n_int = r_int;
        n_q = r_q;  n_r = r_r;  n_vtg_ok = r_vtg_ok;  n_vtg_spd = r_vtg_spd;
        n_grp_all = r_grp_all;  n_grp_idxv = r_grp_idxv;  n_grp_idx = r_grp_idx;
        n_grp_el = r_grp_el;  n_grp_az = r_grp_az;  n_alive = r_alive;
        n_speed = r_speed;  n_heading = r_heading;  n_sat_valid = r_sat_valid;
        n_s2_valid = 1'b0;  n_s2_item = r_s2_item;  n_s2_read = 1'b0;  n_s2_ok = 1'b0;
        w_we = 1'b0;  w_waddr = r_grp_idx;
        w_wdata = {r_grp_el, r_grp_az, w_c127[6:0]};

        if (w_go) begin
            if (i_cmd.is_read) begin
                n_s2_valid = 1'b1;
                n_s2_read  = 1'b1;
                n_s2_ok    = w_rd_in && r_sat_valid[w_raddr];
                n_s2_item  = '0;
                n_s2_item.result_kind   = nsfp_pkg::RK_SLOT;
                n_s2_item.fix_alive     = r_alive;
                n_s2_item.speed_m_per_h = r_speed;
                n_s2_item.heading       = r_heading;
            end else if (i_cmd.cls == nsfp_pkg::BC_DOLLAR) begin
                n_phase = PH_BUSY;  n_fn = '0;  n_letters = '0;  n_len = '0;
                n_vtg_ok = 1'b0;  n_grp_all = 1'b0;  n_grp_idxv = 1'b0;
                n_ne = 1'b0;  n_dot = 1'b0;  n_stop = 1'b0;  n_neg = 1'b0;  n_fd = '0;
                n_int = '0;  n_q = '0;  n_r = '0;  n_first = '0;
            end else if (r_phase == PH_BUSY) begin
                if (i_cmd.cls == nsfp_pkg::BC_COMMA || i_cmd.cls == nsfp_pkg::BC_LF) begin
                    // Close the current field.
                    if (r_fn == '0) begin
                        n_kind = nsfp_pkg::classify(r_letters, r_len);
                    end else begin
                        case (r_kind)
                            nsfp_pkg::K_GGA: begin
                                if (32'(r_fn) == 6 && r_ne) n_alive = (r_int != '0);
                            end
                            nsfp_pkg::K_GLL: begin
                                if (32'(r_fn) == 6 && r_ne) n_alive = (r_first != nsfp_pkg::CH_V);
                            end
                            nsfp_pkg::K_RMC: begin
                                if (32'(r_fn) == 2 && r_ne) n_alive = (r_first != nsfp_pkg::CH_V);
                                if (32'(r_fn) == 7 && r_ne) n_speed = w_spd;
                                if (32'(r_fn) == 8 && r_ne) n_heading = w_c999;
                            end
                            nsfp_pkg::K_VTG: begin
                                if (32'(r_fn) == 1 && r_ne) n_heading = w_c999;
                                if (32'(r_fn) == 5) begin
                                    n_vtg_ok  = r_ne;
                                    n_vtg_spd = w_spd;
                                end
                                if (32'(r_fn) == 6 && r_ne && r_vtg_ok) n_speed = r_vtg_spd;
                                if (32'(r_fn) == 9 && r_ne) n_alive = (r_first != nsfp_pkg::CH_N);
                            end
                            nsfp_pkg::K_GSV: begin
                                // Message number one starts a fresh table.
                                if (32'(r_fn) == 2 && r_ne && !r_neg && r_int == 10'd1)
                                    n_sat_valid = '0;
                                if (w_in_gsv) begin
                                    if (w_pos == 2'd0) begin
                                        n_grp_all  = r_ne;
                                        n_grp_idxv = !r_neg && r_int >= 10'd1 &&
                                                     32'(r_int) <= SAT_SLOTS;
                                        n_grp_idx  = SLOT_W'(32'(r_int) - 1);
                                    end else if (!r_ne) begin
                                        n_grp_all = 1'b0;
                                    end else if (w_pos == 2'd1) begin
                                        n_grp_el = w_c127[6:0];
                                    end else if (w_pos == 2'd2) begin
                                        n_grp_az = w_c511[8:0];
                                    end else if (r_grp_all && r_grp_idxv) begin
                                        w_we = 1'b1;
                                        n_sat_valid[r_grp_idx] = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    n_ne = 1'b0;  n_dot = 1'b0;  n_stop = 1'b0;  n_neg = 1'b0;  n_fd = '0;
                    n_int = '0;  n_q = '0;  n_r = '0;  n_first = '0;
                    if (i_cmd.cls == nsfp_pkg::BC_COMMA) begin
                        if (32'(r_fn) < FIELD_CAP) n_fn = r_fn + FN_W'(1);
                    end else begin
                        n_s2_valid = 1'b1;
                        n_s2_item  = '0;
                        n_s2_item.result_kind   = nsfp_pkg::RK_STATUS;
                        n_s2_item.sentence_type = w_cur_kind;
                        n_s2_item.error_code    =
                            (32'(r_fn) + 1 < 32'(nsfp_pkg::needed_fields(w_cur_kind))) ?
                            nsfp_pkg::ERR_MISSING : nsfp_pkg::ERR_OK;
                        n_s2_item.fix_alive     = n_alive;
                        n_s2_item.speed_m_per_h = n_speed;
                        n_s2_item.heading       = n_heading;
                        n_phase = PH_IDLE;  n_fn = '0;  n_letters = '0;  n_len = '0;
                        n_vtg_ok = 1'b0;  n_grp_all = 1'b0;  n_grp_idxv = 1'b0;
                    end
                end else begin
                    // Accumulate one character.
                    n_ne = 1'b1;
                    if (r_fn == '0) begin
                        if (r_len < 3'd6) n_len = r_len + 3'd1;
                        n_letters = {r_letters[31:0], i_cmd.data_byte};
                    end else begin
                        if (!r_ne) n_first = i_cmd.data_byte;
                        if (!r_stop) begin
                            if (!r_ne && i_cmd.cls == nsfp_pkg::BC_SIGN) begin
                                if (i_cmd.data_byte == nsfp_pkg::CH_MINUS) n_neg = 1'b1;
                            end else if (i_cmd.cls == nsfp_pkg::BC_DIGIT) begin
                                if (!(r_dot && r_fd == 2'd3)) begin
                                    if (!r_dot)
                                        n_int = (w_int_x > 14'(nsfp_pkg::INT_CAP)) ?
                                                nsfp_pkg::INT_CAP : w_int_x[9:0];
                                    else
                                        n_fd = r_fd + 2'd1;
                                    if (w_qsum > 28'(nsfp_pkg::VAL_MAX)) begin
                                        n_q = nsfp_pkg::VAL_MAX;
                                    end else begin
                                        n_q = w_qsum[23:0];
                                    end
                                    n_r = w_nq.r;
                                end
                            end else if (i_cmd.cls == nsfp_pkg::BC_DOT && !r_dot) begin
                                n_dot = 1'b1;
                            end else begin
                                n_stop = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_sat_mem[w_waddr] <= w_wdata;
        if (w_go) r_rd_data <= r_sat_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;  r_fn <= '0;  r_letters <= '0;  r_len <= '0;
            r_kind <= nsfp_pkg::K_OTHER;  r_first <= '0;  r_ne <= 1'b0;
            r_dot <= 1'b0;  r_stop <= 1'b0;  r_neg <= 1'b0;  r_fd <= '0;
            r_int <= '0;  r_q <= '0;  r_r <= '0;  r_vtg_ok <= 1'b0;
            r_grp_all <= 1'b0;  r_grp_idxv <= 1'b0;  r_alive <= 1'b0;
            r_speed <= '0;  r_heading <= '0;  r_sat_valid <= '0;
            r_s2_valid <= 1'b0;  r_s2_read <= 1'b0;  r_s2_ok <= 1'b0;
        end else begin
            r_phase <= n_phase;  r_fn <= n_fn;  r_letters <= n_letters;  r_len <= n_len;
            r_kind <= n_kind;  r_first <= n_first;  r_ne <= n_ne;  r_dot <= n_dot;
            r_stop <= n_stop;  r_neg <= n_neg;  r_fd <= n_fd;  r_int <= n_int;
            r_q <= n_q;  r_r <= n_r;  r_vtg_ok <= n_vtg_ok;  r_grp_all <= n_grp_all;
            r_grp_idxv <= n_grp_idxv;  r_alive <= n_alive;  r_speed <= n_speed;
            r_heading <= n_heading;  r_sat_valid <= n_sat_valid;
            r_s2_valid <= n_s2_valid;  r_s2_read <= n_s2_read;  r_s2_ok <= n_s2_ok;
        end
        r_vtg_spd <= n_vtg_spd;
        r_grp_idx <= n_grp_idx;
        r_grp_el  <= n_grp_el;
        r_grp_az  <= n_grp_az;
        r_s2_item <= n_s2_item;
    end

    // Merge the registered table read into the result.
    always_comb begin
        o_res_valid = r_s2_valid;
        o_res       = r_s2_item;
        if (r_s2_read && r_s2_ok) begin
            o_res.sat_valid     = 1'b1;
            o_res.sat_elevation = r_rd_data[22:16];
            o_res.sat_azimuth   = r_rd_data[15:7];
            o_res.sat_snr       = r_rd_data[6:0];
        end
    end

    a_heading_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading <= 10'd999)
        else $error("heading beyond 999");

    a_idle_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_fn == '0))
        else $error("field count not cleared while idle");

endmodule

// ----- rtl/nmea_sentence_field_parser.sv -----
`timescale 1ns / 1ps

// NMEA 0183 sentence parser. Push one transaction per cycle: either a text byte
// of the receiver stream or a read of one satellite slot. A '$' opens a sentence
// and LF closes it with one status result (type, missing-field error, fix flag,
// speed in m/h, heading); GGA/GLL/RMC/VTG update the fix flag, RMC/VTG update
// speed and heading as each field closes, GSV fills the satellite table (cleared
// on message number 1). Other bytes give no result. A read gives one result with
// the slot contents. The block takes one transaction per clock while the command
// queue has room; each result passes through the command queue, then the parse
// and table read stage, then the result queue write, before it shows on the
// output queue. Input stalls only when results back up: the back end holds once
// the four-entry result queue plus its output stage carry four results, and the
// two-entry command queue then fills. Reset clears the whole satellite table at
// once through per-slot valid bits; no sweep is needed.

module nmea_sentence_field_parser #(
    parameter int SAT_SLOTS      = nsfp_pkg::SAT_SLOTS_DEF,
    parameter int GROUPS_PER_GSV = nsfp_pkg::GROUPS_PER_GSV_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  nsfp_pkg::t_in_item  i_item,
    input  logic                pop,
    output logic                empty,
    output nsfp_pkg::t_out_item o_result
);

    logic                cmd_valid, cmd_pop, res_valid;
    nsfp_pkg::t_cmd      cmd;
    nsfp_pkg::t_out_item res;
    nsfp_pkg::t_q_status outq_st;
    logic [nsfp_pkg::OUTQ_CNT_W-1:0] outq_count;

    // Front end: accept and classify bytes.
    nsfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd)
    );

    assign outq_st.valid = !empty;
    assign outq_st.count = outq_count;

    // Back end: parse fields, hold fix state and the satellite table.
    nsfp_back #(
        .SAT_SLOTS      (SAT_SLOTS),
        .GROUPS_PER_GSV (GROUPS_PER_GSV)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_outq      (outq_st),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result queue decouples the back end from the consumer.
    nsfp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_item   (res),
        .o_count  (outq_count),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

endmodule
